@@ rtl/ect_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expiring capability table package
// Operation and status codes, field widths and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ect_pkg;

    localparam int OP_W     = 2;
    localparam int STAT_W   = 3;
    localparam int CNT_OUT_W = 5;
    localparam int AGE_W    = 8;
    localparam int KEY_HI_W = 32;
    localparam int KEY_MD_W = 64;
    localparam int KEY_LO_W = 64;
    localparam int KEY_W    = KEY_HI_W + KEY_MD_W + KEY_LO_W;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DENIED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOMATCH  = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd4;

    localparam logic [7:0]       DIGEST_BYTES = 8'd20;
    localparam logic [AGE_W-1:0] EXPIRY_RESET = 8'd15;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming word and clear scan state
        logic issue;   // read the slot at the scan index and advance
        logic commit;  // apply the insert or consume and load the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;   // the captured word has to visit every slot
        logic last_issue;  // the scan index sits on the last slot
        logic out_free;    // the result register can take a new word
    } t_dp_stat;

endpackage

@@ rtl/ect_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expiring capability table controller
// Sequences one word through capture, decode, slot scan, drain and commit.
// ----------------------------------------------------------------------------
module ect_ctrl
    import ect_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_dp_stat,
    output t_dp_cmd  o_dp_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_dp_cmd.load   = 1'b0;
        o_dp_cmd.issue  = 1'b0;
        o_dp_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_dp_stat.need_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN: begin
                o_dp_cmd.issue = 1'b1;
                if (i_dp_stat.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_dp_stat.out_free) begin
                    o_dp_cmd.commit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

@@ rtl/ect_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expiring capability table datapath
// Slot memories, valid bits, the scan pipeline and the result register.
// ----------------------------------------------------------------------------
module ect_datapath
    import ect_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_dp_cmd,
    output t_dp_stat             o_dp_stat,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [KEY_HI_W-1:0]  i_key_high,
    input  logic [KEY_MD_W-1:0]  i_key_mid,
    input  logic [KEY_LO_W-1:0]  i_key_low,
    input  logic [7:0]           i_write_length,
    input  logic                 i_caller_privileged,
    input  logic                 i_user_matches,
    input  logic [AGE_W-1:0]     i_expiry,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [STAT_W-1:0]    o_status,
    output logic [CNT_OUT_W-1:0] o_occupancy,
    output logic [CNT_OUT_W-1:0] o_expired_count
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

    // Captured word.
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic             r_ins_ok;
    logic             r_umatch;

    // Slot storage.
    logic [KEY_W-1:0]       r_key_mem [TABLE_DEPTH];
    logic [AGE_W-1:0]       r_age_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CW-1:0]          r_occ;
    logic [CW-1:0]          n_occ;

    // Scan pipeline and search results.
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    r_pidx;
    logic             r_pact;
    logic [KEY_W-1:0] r_rd_key;
    logic [AGE_W-1:0] r_rd_age;
    logic             r_found;
    logic [IW-1:0]    r_best;
    logic [AGE_W-1:0] r_best_age;
    logic [CW-1:0]    r_exp;

    // Result register.
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_out_status;
    logic [CNT_OUT_W-1:0] r_out_occ;
    logic [CNT_OUT_W-1:0] r_out_exp;

    logic              slot_valid;
    logic              key_hit;
    logic [AGE_W:0]    age_inc;
    logic              drop;
    logic              age_wr;
    logic              cand_consume;
    logic              cand_free;
    logic              do_set;
    logic              do_clr;
    logic [STAT_W-1:0] commit_status;
    logic [CW+CNT_OUT_W-1:0] occ_ext;
    logic [CW+CNT_OUT_W-1:0] exp_ext;

    assign slot_valid = r_valid[r_pidx];
    assign key_hit    = (r_rd_key == r_key);
    assign age_inc    = {1'b0, r_rd_age} + {{AGE_W{1'b0}}, 1'b1};

    assign drop   = r_pact && (r_op == OP_TICK) && slot_valid &&
                    (age_inc > {1'b0, i_expiry});
    assign age_wr = r_pact && (r_op == OP_TICK) && slot_valid && !drop;

    assign cand_consume = r_pact && (r_op == OP_CONSUME) && slot_valid && key_hit &&
                          (!r_found || (r_rd_age < r_best_age));
    assign cand_free    = r_pact && (r_op == OP_INSERT) && !slot_valid && !r_found;

    always_comb begin
        commit_status = ST_DENIED;
        do_set        = 1'b0;
        do_clr        = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (!r_ins_ok) begin
                    commit_status = ST_DENIED;
                end else if (r_found) begin
                    commit_status = ST_OK;
                    do_set        = i_dp_cmd.commit;
                end else begin
                    commit_status = ST_FULL;
                end
            end
            OP_TICK: begin
                commit_status = ST_OK;
            end
            OP_CONSUME: begin
                if (r_found) begin
                    commit_status = r_umatch ? ST_OK : ST_MISMATCH;
                    do_clr        = i_dp_cmd.commit;
                end else begin
                    commit_status = ST_NOMATCH;
                end
            end
            default: begin
                commit_status = ST_DENIED;
            end
        endcase
    end

    always_comb begin
        n_occ = r_occ;
        if (drop || do_clr) begin
            n_occ = r_occ - {{(CW-1){1'b0}}, 1'b1};
        end else if (do_set) begin
            n_occ = r_occ + {{(CW-1){1'b0}}, 1'b1};
        end
    end

    assign occ_ext = {{CNT_OUT_W{1'b0}}, n_occ};
    assign exp_ext = {{CNT_OUT_W{1'b0}}, r_exp};

    // Captured word.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_op     <= i_operation;
            r_key    <= {i_key_high, i_key_mid, i_key_low};
            r_ins_ok <= i_caller_privileged && (i_write_length == DIGEST_BYTES);
            r_umatch <= i_user_matches;
        end
    end

    // Slot memories, one read port each with registered data.
    always_ff @(posedge i_clk) begin
        if (do_set) begin
            r_key_mem[r_best] <= r_key;
        end
        if (i_dp_cmd.issue) begin
            r_rd_key <= r_key_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (age_wr) begin
            r_age_mem[r_pidx] <= age_inc[AGE_W-1:0];
        end else if (do_set) begin
            r_age_mem[r_best] <= '0;
        end
        if (i_dp_cmd.issue) begin
            r_rd_age <= r_age_mem[r_idx];
        end
    end

    // Valid bits and the fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else begin
            r_occ <= n_occ;
            if (drop) begin
                r_valid[r_pidx] <= 1'b0;
            end
            if (do_set) begin
                r_valid[r_best] <= 1'b1;
            end
            if (do_clr) begin
                r_valid[r_best] <= 1'b0;
            end
        end
    end

    // Scan control and search results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pact  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_exp   <= '0;
        end else begin
            r_pact <= i_dp_cmd.issue;
            if (i_dp_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_exp   <= '0;
            end else begin
                if (i_dp_cmd.issue) begin
                    r_idx <= r_idx + {{(IW-1){1'b0}}, 1'b1};
                end
                if (cand_consume || cand_free) begin
                    r_found <= 1'b1;
                end
                if (drop) begin
                    r_exp <= r_exp + {{(CW-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.issue) begin
            r_pidx <= r_idx;
        end
        if (cand_consume || cand_free) begin
            r_best     <= r_pidx;
            r_best_age <= r_rd_age;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit) begin
            r_out_status <= commit_status;
            r_out_occ    <= occ_ext[CNT_OUT_W-1:0];
            r_out_exp    <= exp_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_occupancy     = r_out_occ;
    assign o_expired_count = r_out_exp;

    assign o_dp_stat.need_scan  = (r_op == OP_TICK) || (r_op == OP_CONSUME) ||
                                  ((r_op == OP_INSERT) && r_ins_ok);
    assign o_dp_stat.last_issue = (r_idx == LAST_IDX);
    assign o_dp_stat.out_free   = !r_out_valid || !i_stall;

    // The fill count always agrees with the valid bits.
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("fill count disagrees with valid bits");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= DEPTH_CNT)
        else $error("fill count exceeds table depth");

    // A result is never loaded over one that is still stalled.
    a_commit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.commit |-> (!r_out_valid || !i_stall))
        else $error("result overwritten while stalled");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.commit |=> o_valid)
        else $error("committed result not presented");

endmodule

@@ rtl/expiring_capability_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expiring capability table unit
// Bounded table of one-time 160-bit capability digests with tick-driven
// expiry, insert, and consume-by-match.
// ----------------------------------------------------------------------------
// Each input word is captured, then decoded. A word that needs a scan then
// reads each slot's key and age from the slot memories in turn, a drain step
// finishes the last slot, and a commit step applies the change and loads the
// result register. The slot memories have a single read port, and that port
// visits one slot per cycle. Words that need no scan (a denied insert or an
// unknown operation) go from decode straight to commit. The result sits in
// its own register, so the next word is accepted while the previous result
// still waits to be taken. The expiry register is written over the APB-style
// port at byte address 0 and should only be written while the unit is idle.
module expiring_capability_table_unit
    import ect_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Input channel.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [KEY_HI_W-1:0]  i_key_high,
    input  logic [KEY_MD_W-1:0]  i_key_mid,
    input  logic [KEY_LO_W-1:0]  i_key_low,
    input  logic [7:0]           i_write_length,
    input  logic                 i_caller_privileged,
    input  logic                 i_user_matches,

    // Result channel.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [CNT_OUT_W-1:0] o_occupancy,
    output logic [CNT_OUT_W-1:0] o_expired_count,

    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic [AGE_W-1:0] r_expiry;
    logic             cfg_hit;

    // The only register is expiry_ticks at byte address 0. Address bit 2
    // selects the next register slot, which does not exist, so writes there
    // are dropped and reads return zero.
    assign pready  = 1'b1;
    assign cfg_hit = !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= EXPIRY_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_expiry <= pwdata[AGE_W-1:0];
        end
    end

    assign prdata = cfg_hit ? {{(32-AGE_W){1'b0}}, r_expiry} : 32'd0;

    // The controller only sequences; all storage and compares live in the
    // datapath.
    ect_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_dp_stat (dp_stat),
        .o_dp_cmd  (dp_cmd)
    );

    ect_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_dp_cmd            (dp_cmd),
        .o_dp_stat           (dp_stat),
        .i_operation         (i_operation),
        .i_key_high          (i_key_high),
        .i_key_mid           (i_key_mid),
        .i_key_low           (i_key_low),
        .i_write_length      (i_write_length),
        .i_caller_privileged (i_caller_privileged),
        .i_user_matches      (i_user_matches),
        .i_expiry            (r_expiry),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_occupancy         (o_occupancy),
        .o_expired_count     (o_expired_count)
    );

endmodule

@@ test/capability_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capability table checker
// Keeps a mirror of the capability table from the words that the unit
// accepts, predicts each result word and compares it field by field with
// the words that leave the unit. Register traffic on the configuration port
// updates the mirrored expiry setting and is checked on reads.
// ----------------------------------------------------------------------------
module capability_table_checker
    import ect_pkg::*;
#(
    parameter int         TABLE_DEPTH = 16,
    parameter logic [2:0] EXPIRY_ADDR = 3'd0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [KEY_HI_W-1:0]  i_key_high,
    input  logic [KEY_MD_W-1:0]  i_key_mid,
    input  logic [KEY_LO_W-1:0]  i_key_low,
    input  logic [7:0]           i_write_length,
    input  logic                 i_caller_privileged,
    input  logic                 i_user_matches,

    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [STAT_W-1:0]    i_status,
    input  logic [CNT_OUT_W-1:0] i_occupancy,
    input  logic [CNT_OUT_W-1:0] i_expired_count,

    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [2:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic [31:0]          i_prdata,
    input  logic                 i_pready,

    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] occupancy;
        logic [CNT_OUT_W-1:0] expired;
    } t_outcome;

    // Mirrored table and expiry setting.
    logic             slot_live [TABLE_DEPTH];
    logic [KEY_W-1:0] slot_key  [TABLE_DEPTH];
    logic [AGE_W-1:0] slot_age  [TABLE_DEPTH];
    logic [AGE_W-1:0] expiry;

    t_outcome outcome_q[$];
    int       mismatches = 0;
    int       compared = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what,
                 got, want);
        mismatches++;
    endtask

    // Applies one accepted word to the mirrored table and returns the result
    // word that it should produce.
    task automatic apply_capability_word(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key,
                                         input logic [7:0] len, input logic priv,
                                         input logic umatch, output t_outcome res);
        int             free_slot;
        int             best;
        int             live;
        logic [AGE_W:0] aged;
        logic [CNT_OUT_W-1:0] dropped;
        free_slot  = -1;
        best       = -1;
        live       = 0;
        dropped    = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (!priv || len != DIGEST_BYTES) begin
                    res.status = ST_DENIED;
                end else begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                        if (!slot_live[i]) free_slot = i;
                    if (free_slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_live[free_slot] = 1'b1;
                        slot_key[free_slot]  = key;
                        slot_age[free_slot]  = '0;
                    end
                end
            end
            OP_TICK: begin
                // The age grows in one extra bit, so 255 always expires.
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_live[i]) begin
                        aged = {1'b0, slot_age[i]} + {{AGE_W{1'b0}}, 1'b1};
                        if (aged > {1'b0, expiry}) begin
                            slot_live[i] = 1'b0;
                            dropped++;
                        end else begin
                            slot_age[i] = aged[AGE_W-1:0];
                        end
                    end
                end
            end
            OP_CONSUME: begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (slot_live[i] && slot_key[i] == key)
                        if (best < 0 || slot_age[i] < slot_age[best]) best = i;
                if (best < 0) begin
                    res.status = ST_NOMATCH;
                end else begin
                    slot_live[best] = 1'b0;
                    res.status = umatch ? ST_OK : ST_MISMATCH;
                end
            end
            default: begin
                res.status = ST_DENIED;
            end
        endcase
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_live[i]) live++;
        res.occupancy = CNT_OUT_W'(live);
        res.expired   = dropped;
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
            expiry = EXPIRY_RESET;
            outcome_q.delete();
        end else begin
            // Results are taken before new words are predicted, so a stray
            // result can never pair with the word accepted at the same edge.
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_occupancy, i_expired_count};
                if (outcome_q.size() == 0) begin
                    flag_mismatch("result word with nothing outstanding, status",
                                  32'(got.status), 32'(ST_OK));
                end else begin
                    want = outcome_q.pop_front();
                    compared++;
                    if (got.status !== want.status)
                        flag_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.occupancy !== want.occupancy)
                        flag_mismatch("occupancy", 32'(got.occupancy),
                                      32'(want.occupancy));
                    if (got.expired !== want.expired)
                        flag_mismatch("expired count", 32'(got.expired),
                                      32'(want.expired));
                end
            end
            if (i_psel && i_penable && i_pready && i_paddr == EXPIRY_ADDR) begin
                if (i_pwrite)
                    expiry = i_pwdata[AGE_W-1:0];
                else if (i_prdata !== 32'(expiry))
                    flag_mismatch("expiry register read", i_prdata, 32'(expiry));
            end
            if (i_in_valid && !i_in_stall) begin
                apply_capability_word(i_operation, {i_key_high, i_key_mid, i_key_low},
                                      i_write_length, i_caller_privileged,
                                      i_user_matches, want);
                outcome_q.push_back(want);
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= mismatches;
        o_checked    <= compared;
    end

endmodule

@@ test/expiring_capability_table_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expiring capability table unit testbench
// Drives insert, tick and consume words into the unit with random gaps and
// result-side stalls, reprograms the expiry register between phases and
// leaves all prediction and comparison to the checker beside the unit.
// ----------------------------------------------------------------------------
module expiring_capability_table_unit_tb;
    import ect_pkg::*;

    localparam int         TABLE_DEPTH = 16;
    localparam logic [2:0] EXPIRY_ADDR = 3'd0;
    // The fourth operation code is unused by the unit and must be refused.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    // Every run, even with every gap and stall at its longest, ends far
    // below this count.
    localparam int CYCLE_LIMIT = 1_500_000;
    // Long enough to cover any late result.
    localparam int DRAIN_CYCLES = 4 * (TABLE_DEPTH + 4);

    typedef logic [KEY_W-1:0] t_digest;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [OP_W-1:0]      i_operation = OP_TICK;
    logic [KEY_HI_W-1:0]  i_key_high = '0;
    logic [KEY_MD_W-1:0]  i_key_mid = '0;
    logic [KEY_LO_W-1:0]  i_key_low = '0;
    logic [7:0]           i_write_length = DIGEST_BYTES;
    logic                 i_caller_privileged = 1'b0;
    logic                 i_user_matches = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [CNT_OUT_W-1:0] o_occupancy;
    logic [CNT_OUT_W-1:0] o_expired_count;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int      fail_count;
    int      pending;
    int      checked;
    int      words_sent = 0;
    int      cycles = 0;
    int      stall_run = 0;
    int      last_expiry = 0;
    // While quiet is set neither side idles, so the unit runs flat out.
    logic    quiet = 1'b0;
    t_digest key_pool [8];

    expiring_capability_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_key_high         (i_key_high),
        .i_key_mid          (i_key_mid),
        .i_key_low          (i_key_low),
        .i_write_length     (i_write_length),
        .i_caller_privileged(i_caller_privileged),
        .i_user_matches     (i_user_matches),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_occupancy        (o_occupancy),
        .o_expired_count    (o_expired_count),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    capability_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .EXPIRY_ADDR(EXPIRY_ADDR)
    ) i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_operation        (i_operation),
        .i_key_high         (i_key_high),
        .i_key_mid          (i_key_mid),
        .i_key_low          (i_key_low),
        .i_write_length     (i_write_length),
        .i_caller_privileged(i_caller_privileged),
        .i_user_matches     (i_user_matches),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_status           (o_status),
        .i_occupancy        (o_occupancy),
        .i_expired_count    (o_expired_count),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_prdata           (prdata),
        .i_pready           (pready),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Idle lengths: most gaps are short or absent, a few are long enough to
    // let the unit drain completely.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 20);
        else return $urandom_range(30, 120);
    endfunction

    function automatic t_digest random_digest();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // The result side stalls in runs of random length. A run of zero means
    // the stall can change on every cycle, which puts gaps on every phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_run <= 0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall   <= ($urandom_range(0, 2) == 0);
            stall_run <= idle_len();
        end
    end

    // Presents one word and holds it until the unit takes it. Valid stays
    // high when the next word follows at once, so it is never lowered and
    // raised again within one step.
    task automatic send_word(input logic [OP_W-1:0] op, input t_digest key,
                             input logic [7:0] len, input logic priv,
                             input logic umatch);
        int gap;
        i_valid             <= 1'b1;
        i_operation         <= op;
        i_key_high          <= key[KEY_W-1 -: KEY_HI_W];
        i_key_mid           <= key[KEY_MD_W+KEY_LO_W-1 -: KEY_MD_W];
        i_key_low           <= key[KEY_LO_W-1:0];
        i_write_length      <= len;
        i_caller_privileged <= priv;
        i_user_matches      <= umatch;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        gap = quiet ? 0 : idle_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drops valid so the last word is not taken twice.
    task automatic hold_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A setup and an access phase; pready is honored even though the
    // unit keeps it high. The trailing edge keeps psel from being lowered and
    // raised in the same step on back-to-back accesses.
    task automatic reg_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= EXPIRY_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // The expiry setting only changes once the unit has returned every
    // result, then the new value is read back.
    task automatic set_expiry(input logic [AGE_W-1:0] value);
        hold_input();
        while (pending != 0) @(posedge i_clk);
        reg_access(1'b1, 32'(value));
        reg_access(1'b0, '0);
        last_expiry = int'(value);
    endtask

    // One random word. Most words are well formed and draw their digest from
    // a small pool, so consumes find matches and duplicates build up; the
    // rest carry random digests, bad lengths, unprivileged callers or the
    // reserved operation.
    task automatic random_word(input int ins_w, input int tick_w, input int cons_w);
        int              r;
        logic [OP_W-1:0] op;
        t_digest         key;
        logic [7:0]      len;
        r = $urandom_range(0, 99);
        if (r < ins_w) op = OP_INSERT;
        else if (r < ins_w + tick_w) op = OP_TICK;
        else if (r < ins_w + tick_w + cons_w) op = OP_CONSUME;
        else op = OP_RESERVED;
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)]
                                            : random_digest();
        len = ($urandom_range(0, 9) != 0) ? DIGEST_BYTES : 8'($urandom_range(0, 255));
        send_word(op, key, len, ($urandom_range(0, 9) != 0), ($urandom_range(0, 3) != 0));
    endtask

    // A phase renews the random part of the digest pool and then sends n
    // words with the given operation mix; whatever is left over goes to the
    // reserved operation.
    task automatic run_phase(input int n, input int ins_w, input int tick_w,
                             input int cons_w);
        for (int i = 2; i < 8; i++) key_pool[i] = random_digest();
        repeat (n) random_word(ins_w, tick_w, cons_w);
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The expiry register must come out of reset at fifteen.
        reg_access(1'b0, '0);
        last_expiry = int'(EXPIRY_RESET);

        // Directed opening: empty-table consume, the refused inserts, the
        // reserved operation, duplicate digests of different age, a consume
        // by the wrong user, no match, then a full table.
        send_word(OP_CONSUME, '0, DIGEST_BYTES, 1'b1, 1'b1);
        send_word(OP_INSERT, '1, DIGEST_BYTES, 1'b0, 1'b1);
        send_word(OP_INSERT, '0, 8'd19, 1'b1, 1'b1);
        send_word(OP_INSERT, '0, 8'hFF, 1'b1, 1'b0);
        send_word(OP_RESERVED, random_digest(), DIGEST_BYTES, 1'b1, 1'b1);
        send_word(OP_INSERT, '0, DIGEST_BYTES, 1'b1, 1'b0);
        send_word(OP_INSERT, '1, DIGEST_BYTES, 1'b1, 1'b1);
        send_word(OP_TICK, '1, DIGEST_BYTES, 1'b1, 1'b1);
        send_word(OP_INSERT, '1, DIGEST_BYTES, 1'b1, 1'b1);
        // The younger copy goes first, then the older one by the wrong user.
        send_word(OP_CONSUME, '1, DIGEST_BYTES, 1'b0, 1'b1);
        send_word(OP_CONSUME, '1, DIGEST_BYTES, 1'b1, 1'b0);
        send_word(OP_CONSUME, '1, DIGEST_BYTES, 1'b1, 1'b1);
        for (int i = 1; i < TABLE_DEPTH; i++)
            send_word(OP_INSERT, random_digest(), DIGEST_BYTES, 1'b1, 1'b1);
        send_word(OP_INSERT, '1, DIGEST_BYTES, 1'b1, 1'b1);
        send_word(OP_TICK, '0, DIGEST_BYTES, 1'b0, 1'b0);

        // Reset setting with a balanced mix.
        run_phase(300, 40, 20, 35);
        // Longest life: ticks dominate so early entries live through every
        // age and drop on the wrap past 255.
        set_expiry(8'd255);
        run_phase(380, 15, 80, 4);
        // Shortest legal life.
        set_expiry(8'd1);
        run_phase(200, 45, 25, 25);
        // Zero expiry clears the table on every tick; run without idling.
        set_expiry(8'd0);
        quiet = 1'b1;
        run_phase(120, 45, 25, 25);
        quiet = 1'b0;
        set_expiry(8'($urandom_range(2, 254)));
        run_phase(300, 40, 20, 35);

        // Wait for every result, then give a late word time to show up.
        hold_input();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words over expiry settings 15, 255, 1, 0 and %0d;",
                 words_sent, last_expiry);
        $display("%0d result words compared, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
